// ===== rtl/pbts_pkg.sv =====
`default_nettype none
package pbts_pkg;
  localparam int unsigned QueueDepth = 32;
  localparam int unsigned BatchMax = 4;
  localparam int unsigned Levels = 3;
  localparam int unsigned IdW = 11;
  localparam int unsigned RegW = 8;
  localparam int unsigned LenW = 3;
  localparam int unsigned DataW = 32;
  localparam int unsigned LimitW = 3;
  localparam logic [LimitW-1:0] LimitReset = 3'd4;

  localparam logic [1:0] KindReply = 2'd0;
  localparam logic [1:0] KindFrame = 2'd1;
  localparam logic [1:0] KindEmpty = 2'd2;

  localparam logic ActEnqueue = 1'b0;
  localparam logic ActTick = 1'b1;

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [RegW-1:0]  rcode;
    logic [LenW-1:0]  len;
    logic [DataW-1:0] data;
  } frame_t;

  // per-level control from the sequencer
  typedef struct packed {
    logic push;   // load tail cell from in frame
    logic shift;  // rotate ring by one
    logic keep;   // rotated frame stays (else removed)
  } cell_ctl_t;
endpackage
`default_nettype wire

// ===== rtl/pbts_cell.sv =====
`default_nettype none
// One frame slot of a level ring. Slot 0 is the head.
module pbts_cell
  import pbts_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   load_i,
  input  wire frame_t d_i,
  output frame_t      q_o
);
  frame_t frame_q;
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      frame_q <= d_i;
    end
  end
  assign q_o = frame_q;
endmodule
`default_nettype wire

// ===== rtl/pbts_level.sv =====
`default_nettype none
// One priority FIFO as a chain of cells. During a scan the head frame leaves
// cell 0 and, when kept, reenters at slot fill-1 after all cells shifted down.
module pbts_level
  import pbts_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire cell_ctl_t ctl_i,
  input  wire frame_t  in_i,
  output frame_t       head_o,
  output logic [$clog2(Depth+1)-1:0] fill_o
);
  localparam int unsigned FillW = $clog2(Depth+1);
  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [FillW-1:0] fill_d, fill_q;
  frame_t q [Depth];
  frame_t d [Depth];
  logic   ld [Depth];
  logic [IdxW-1:0] tail;

  always_comb begin
    tail = IdxW'(fill_q - FillW'(1));
    if (ctl_i.push) tail = fill_q[IdxW-1:0];
  end

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    always_comb begin
      if (ctl_i.shift) begin
        d[i] = (i == Depth-1) ? q[0] : q[(i+1) % Depth];
        if (IdxW'(i) == tail) d[i] = q[0];
        ld[i] = 1'b1;
      end else begin
        d[i] = in_i;
        ld[i] = ctl_i.push && (IdxW'(i) == tail);
      end
    end
    pbts_cell u_cell (
      .clk_i (clk_i),
      .load_i(ld[i]),
      .d_i   (d[i]),
      .q_o   (q[i])
    );
  end

  always_comb begin
    fill_d = fill_q;
    if (ctl_i.push) fill_d = fill_q + FillW'(1);
    else if (ctl_i.shift && !ctl_i.keep) fill_d = fill_q - FillW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  assign head_o = q[0];
  assign fill_o = fill_q;
endmodule
`default_nettype wire

// ===== rtl/priority_batch_tx_scheduler.sv =====
`default_nettype none
// Priority batch transmit scheduler. Each priority level is a ring of frame
// cells; a tick rotates every stored frame of every level once through the
// head cell, one frame per cycle, with a step after each level to move on and a
// closing StDone state, so busy stays high from the accepted tick through
// that closing state and the final result of the tick follows in the next
// cycle, when busy is already low. An enqueue never raises busy and is
// answered in the cycle after it is accepted, so enqueues may follow back
// to back. A taken frame is reported one take later, or at the end of the
// scan, so that the final frame carries last_o. Results appear one per
// cycle with valid_o and the receiver cannot stall them; last_o marks the
// final result of a request.
module priority_batch_tx_scheduler
  import pbts_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepth,
  parameter int unsigned BATCH_MAX = BatchMax,
  parameter int unsigned LEVELS = Levels
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               action_i,
  input  wire logic [1:0]         level_i,
  input  wire logic [IdW-1:0]     dest_id_i,
  input  wire logic [RegW-1:0]    reg_code_i,
  input  wire logic [LenW-1:0]    byte_count_i,
  input  wire logic [DataW-1:0]   payload_i,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [LimitW-1:0]  cfg_data_i,
  output logic                    valid_o,
  output logic [1:0]              kind_o,
  output logic                    accepted_o,
  output logic [IdW-1:0]          out_id_o,
  output logic [RegW-1:0]         out_reg_o,
  output logic [LenW-1:0]         out_len_o,
  output logic [DataW-1:0]        out_payload_o,
  output logic                    last_o
);
  localparam int unsigned FillW = $clog2(QUEUE_DEPTH+1);
  localparam int unsigned LvW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int unsigned CntW = $clog2(BATCH_MAX+1);
  localparam int unsigned BiW = $clog2(BATCH_MAX > 1 ? BATCH_MAX : 2);
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  logic [1:0] st_q, st_d;
  logic [LimitW-1:0] limit_q;
  logic [LvW-1:0] lv_q, lv_d;
  logic [FillW-1:0] rem_q, rem_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [IdW-1:0] ids_q [BATCH_MAX];
  frame_t in_frame;
  frame_t head [LEVELS];
  logic [FillW-1:0] fill [LEVELS];
  cell_ctl_t ctl [LEVELS];
  logic [CntW-1:0] lim;
  logic take, dup;
  frame_t hf;
  logic enq_ok;
  logic enq_go;

  frame_t pend_q;
  logic pend_v_q;
  logic res_valid_d, res_valid_q;
  logic [1:0] res_kind_d, res_kind_q;
  logic res_acc_d, res_acc_q;
  frame_t res_frame_d, res_frame_q;
  logic res_last_d, res_last_q;

  assign in_frame = '{id: dest_id_i, rcode: reg_code_i, len: byte_count_i,
                      data: payload_i};
  assign busy = (st_q != StIdle);
  assign cfg_ready_o = 1'b1;
  assign enq_go = start && !busy && (action_i == ActEnqueue);

  always_comb begin
    lim = (limit_q == '0) ? CntW'(1) : CntW'(limit_q);
    if (32'(limit_q) > BATCH_MAX) lim = CntW'(BATCH_MAX);
  end

  assign hf = head[lv_q];
  always_comb begin
    dup = 1'b0;
    for (int i = 0; i < BATCH_MAX; i++) begin
      if (CntW'(i) < cnt_q && ids_q[i] == hf.id) dup = 1'b1;
    end
  end
  assign take = (st_q == StScan) && (rem_q != '0) && (cnt_q < lim) && !dup;

  always_comb begin
    enq_ok = 1'b0;
    for (int l = 0; l < LEVELS; l++) begin
      if (32'(level_i) == l && fill[l] != FillW'(QUEUE_DEPTH)) enq_ok = 1'b1;
    end
  end

  for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
    always_comb begin
      ctl[l].push = enq_go && enq_ok && (32'(level_i) == l);
      ctl[l].shift = (st_q == StScan) && (lv_q == LvW'(l)) && (rem_q != '0);
      ctl[l].keep = !take;
    end
    pbts_level #(.Depth(QUEUE_DEPTH)) u_level (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctl_i (ctl[l]),
      .in_i  (in_frame),
      .head_o(head[l]),
      .fill_o(fill[l])
    );
  end

  always_comb begin
    st_d = st_q;
    lv_d = lv_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    case (st_q)
      StIdle: begin
        if (start && action_i == ActTick) begin
          st_d = StScan;
          lv_d = LvW'(LEVELS-1);
          rem_d = fill[LEVELS-1];
          cnt_d = '0;
        end
      end
      StScan: begin
        if (rem_q != '0) begin
          rem_d = rem_q - FillW'(1);
          if (take) cnt_d = cnt_q + CntW'(1);
        end else if (lv_q == '0) begin
          st_d = StDone;
        end else begin
          lv_d = lv_q - LvW'(1);
          rem_d = fill[lv_q - LvW'(1)];
        end
      end
      StDone: st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  // a taken frame waits in pend_q until the next take or the end of the scan
  always_comb begin
    res_valid_d = 1'b0;
    res_kind_d = KindReply;
    res_acc_d = 1'b0;
    res_frame_d = '0;
    res_last_d = 1'b0;
    if (enq_go) begin
      res_valid_d = 1'b1;
      res_acc_d = enq_ok;
      res_last_d = 1'b1;
    end else if (take && pend_v_q) begin
      res_valid_d = 1'b1;
      res_kind_d = KindFrame;
      res_frame_d = pend_q;
    end else if (st_q == StDone) begin
      res_valid_d = 1'b1;
      res_last_d = 1'b1;
      if (pend_v_q) begin
        res_kind_d = KindFrame;
        res_frame_d = pend_q;
      end else begin
        res_kind_d = KindEmpty;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      limit_q <= LimitReset;
      lv_q <= '0;
      rem_q <= '0;
      cnt_q <= '0;
      res_valid_q <= 1'b0;
      res_kind_q <= KindReply;
      res_acc_q <= 1'b0;
      res_frame_q <= '0;
      res_last_q <= 1'b0;
    end else begin
      st_q <= st_d;
      lv_q <= lv_d;
      rem_q <= rem_d;
      cnt_q <= cnt_d;
      if (cfg_valid_i && cfg_ready_o) limit_q <= cfg_data_i;
      res_valid_q <= res_valid_d;
      res_kind_q <= res_kind_d;
      res_acc_q <= res_acc_d;
      res_frame_q <= res_frame_d;
      res_last_q <= res_last_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
    end else if (take) begin
      pend_v_q <= 1'b1;
    end else if (st_q == StDone) begin
      pend_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      pend_q <= hf;
      ids_q[cnt_q[BiW-1:0]] <= hf.id;
    end
  end

  assign valid_o = res_valid_q;
  assign kind_o = res_kind_q;
  assign accepted_o = res_acc_q;
  assign out_id_o = res_frame_q.id;
  assign out_reg_o = res_frame_q.rcode;
  assign out_len_o = res_frame_q.len;
  assign out_payload_o = res_frame_q.data;
  assign last_o = res_last_q;

  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && kind_o != KindFrame |-> last_o);
  a_kind_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (kind_o == KindReply || kind_o == KindFrame || kind_o == KindEmpty));
  a_quiet_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_o |-> (out_payload_o == '0 && out_id_o == '0 && !last_o));
  a_state_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == StIdle || st_q == StScan || st_q == StDone);
  a_pend_in_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_v_q |-> st_q != StIdle);
endmodule
`default_nettype wire

// ===== sim/priority_batch_tx_scheduler_tb.sv =====
`timescale 1ns / 100ps
module priority_batch_tx_scheduler_tb;
  import pbts_pkg::*;

  typedef struct {
    logic [1:0]       kind;
    logic             accepted;
    logic [IdW-1:0]   id;
    logic [RegW-1:0]  rcode;
    logic [LenW-1:0]  len;
    logic [DataW-1:0] data;
    logic             last;
  } sched_result_t;

  localparam int unsigned StallLimit = 2000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic action_i = ActEnqueue;
  logic [1:0] level_i = '0;
  logic [IdW-1:0] dest_id_i = '0;
  logic [RegW-1:0] reg_code_i = '0;
  logic [LenW-1:0] byte_count_i = '0;
  logic [DataW-1:0] payload_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [LimitW-1:0] cfg_data_i = '0;
  logic valid_o;
  logic [1:0] kind_o;
  logic accepted_o;
  logic [IdW-1:0] out_id_o;
  logic [RegW-1:0] out_reg_o;
  logic [LenW-1:0] out_len_o;
  logic [DataW-1:0] out_payload_o;
  logic last_o;

  priority_batch_tx_scheduler dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .action_i(action_i), .level_i(level_i), .dest_id_i(dest_id_i),
    .reg_code_i(reg_code_i), .byte_count_i(byte_count_i), .payload_i(payload_i),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i),
    .valid_o(valid_o), .kind_o(kind_o), .accepted_o(accepted_o),
    .out_id_o(out_id_o), .out_reg_o(out_reg_o), .out_len_o(out_len_o),
    .out_payload_o(out_payload_o), .last_o(last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow copy of the queues
  frame_t queue_frames [Levels][QueueDepth];
  int unsigned queue_fill [Levels];
  logic [LimitW-1:0] batch_limit;
  sched_result_t pending_results[$];

  int errors = 0;
  int n_requests = 0;
  int n_ticks = 0;
  int n_results = 0;
  int n_refused = 0;
  int stall_cycles = 0;
  bit no_idle = 1'b0;

  task automatic report_mismatch(input string what);
    errors++;
    $display("[%0t] MISMATCH %s", $time, what);
  endtask

  function automatic sched_result_t make_result(logic [1:0] kind, logic acc,
                                                frame_t f, logic last);
    sched_result_t r;
    r.kind = kind;
    r.accepted = acc;
    r.id = f.id;
    r.rcode = f.rcode;
    r.len = f.len;
    r.data = f.data;
    r.last = last;
    return r;
  endfunction

  function automatic void enqueue_frame(logic [1:0] lvl, frame_t f);
    frame_t blank;
    logic acc;
    blank = '0;
    acc = 1'b0;
    if (lvl < Levels && queue_fill[lvl] < QueueDepth) begin
      queue_frames[lvl][queue_fill[lvl]] = f;
      queue_fill[lvl]++;
      acc = 1'b1;
    end
    if (!acc) n_refused++;
    pending_results.push_back(make_result(KindReply, acc, blank, 1'b1));
  endfunction

  function automatic void build_batch();
    int unsigned lim, cnt, w;
    logic [IdW-1:0] ids [BatchMax];
    frame_t f;
    frame_t blank;
    bit take;
    blank = '0;
    cnt = 0;
    lim = batch_limit;
    if (lim < 1) lim = 1;
    if (lim > BatchMax) lim = BatchMax;
    for (int lv = Levels - 1; lv >= 0; lv--) begin
      w = 0;
      for (int unsigned r = 0; r < queue_fill[lv]; r++) begin
        f = queue_frames[lv][r];
        take = cnt < lim;
        for (int unsigned i = 0; take && i < cnt; i++)
          if (ids[i] == f.id) take = 1'b0;
        if (take) begin
          ids[cnt] = f.id;
          pending_results.push_back(make_result(KindFrame, 1'b0, f, 1'b0));
          cnt++;
        end else begin
          queue_frames[lv][w] = f;
          w++;
        end
      end
      queue_fill[lv] = w;
    end
    if (cnt == 0)
      pending_results.push_back(make_result(KindEmpty, 1'b0, blank, 1'b1));
    else
      pending_results[pending_results.size() - 1].last = 1'b1;
  endfunction

  always @(posedge clk_i) begin
    sched_result_t e;
    if (rst_ni && valid_o) begin
      n_results++;
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        e = pending_results.pop_front();
        if (kind_o !== e.kind)
          report_mismatch($sformatf("kind %0d exp %0d", kind_o, e.kind));
        if (accepted_o !== e.accepted)
          report_mismatch($sformatf("accepted %0d exp %0d", accepted_o, e.accepted));
        if (out_id_o !== e.id)
          report_mismatch($sformatf("out_id %0h exp %0h", out_id_o, e.id));
        if (out_reg_o !== e.rcode)
          report_mismatch($sformatf("out_reg %0h exp %0h", out_reg_o, e.rcode));
        if (out_len_o !== e.len)
          report_mismatch($sformatf("out_len %0d exp %0d", out_len_o, e.len));
        if (out_payload_o !== e.data)
          report_mismatch($sformatf("out_payload %0h exp %0h", out_payload_o, e.data));
        if (last_o !== e.last)
          report_mismatch($sformatf("last %0d exp %0d", last_o, e.last));
      end
    end
  end

  // watchdog: cycles without any request, result or config write
  always @(posedge clk_i) begin
    if ((start && !busy) || valid_o || (cfg_valid_i && cfg_ready_o) || !rst_ni)
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= StallLimit) begin
      $display("watchdog expired");
      $display("Mismatches found");
      $finish;
    end
  end

  // leaves start high; caller or next call decides
  task automatic send_request(input logic act, input logic [1:0] lvl,
                              input logic [IdW-1:0] id, input logic [RegW-1:0] rc,
                              input logic [LenW-1:0] len, input logic [DataW-1:0] data);
    frame_t f;
    int gap;
    gap = 0;
    while (!no_idle && $urandom_range(99) < 27) gap++;
    if (gap > 0) begin
      @(negedge clk_i);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start = 1'b1;
    action_i = act;
    level_i = lvl;
    dest_id_i = id;
    reg_code_i = rc;
    byte_count_i = len;
    payload_i = data;
    do @(posedge clk_i); while (busy);
    n_requests++;
    if (act == ActTick) begin
      n_ticks++;
      build_batch();
    end else begin
      f.id = id;
      f.rcode = rc;
      f.len = len;
      f.data = data;
      enqueue_frame(lvl, f);
    end
  endtask

  task automatic enqueue(input logic [1:0] lvl, input logic [IdW-1:0] id);
    send_request(ActEnqueue, lvl, id, RegW'($urandom), LenW'($urandom_range(7)),
                 DataW'($urandom));
  endtask

  task automatic tick();
    send_request(ActTick, 2'($urandom), IdW'($urandom), RegW'($urandom),
                 LenW'($urandom), DataW'($urandom));
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    start = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    while (busy) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_limit(input logic [LimitW-1:0] value);
    wait_drained();
    cfg_valid_i = 1'b1;
    cfg_data_i = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    batch_limit = value;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic random_request(input int id_span);
    logic [IdW-1:0] id;
    id = ($urandom_range(9) == 0) ? IdW'($urandom) : IdW'($urandom_range(id_span));
    if ($urandom_range(99) < 30)
      tick();
    else
      enqueue(($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2)), id);
  endtask

  task automatic test_directed();
    tick();
    send_request(ActEnqueue, 2'd0, '0, '0, '0, '0);
    send_request(ActEnqueue, 2'd2, '1, '1, 3'd7, '1);
    send_request(ActEnqueue, 2'd3, 11'h2aa, 8'h55, 3'd4, 32'h5555_aaaa);
    send_request(ActEnqueue, 2'd1, 11'd5, 8'h12, 3'd4, 32'h0403_0201);
    send_request(ActEnqueue, 2'd1, 11'd5, 8'h34, 3'd2, 32'hdead_beef);
    send_request(ActEnqueue, 2'd2, 11'd5, 8'h56, 3'd1, 32'h0000_00ff);
    send_request(ActEnqueue, 2'd0, '1, 8'h78, 3'd3, 32'hcafe_f00d);
    send_request(ActEnqueue, 2'd0, 11'd9, 8'h9a, 3'd0, 32'h1234_5678);
    tick();
    tick();
    tick();
    tick();
  endtask

  task automatic test_full_level();
    write_limit(3'd4);
    for (int i = 0; i < QueueDepth + 2; i++) enqueue(2'd2, IdW'(i % 3));
    enqueue(2'd1, 11'd1);
    repeat (4) tick();
  endtask

  task automatic test_limit_sweep();
    for (int v = 0; v < 8; v++) begin
      write_limit(LimitW'(v));
      repeat (25) random_request(7);
    end
  endtask

  task automatic test_random();
    write_limit(3'($urandom_range(1, 4)));
    repeat (80) random_request(5);
    no_idle = 1'b1;
    repeat (60) random_request(15);
    no_idle = 1'b0;
    write_limit(3'd1);
    repeat (40) random_request(3);
    write_limit(3'd4);
    repeat (40) random_request(31);
  endtask

  initial begin
    batch_limit = LimitReset;
    for (int l = 0; l < Levels; l++) queue_fill[l] = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_full_level();
    test_limit_sweep();
    test_random();
    wait_drained();
    repeat (110) @(posedge clk_i);
    $display("Covered %0d requests (%0d ticks, %0d refused enqueues), %0d results,",
             n_requests, n_ticks, n_refused, n_results);
    $display("batch limits 0 through 7, full and out-of-range levels, duplicate ids.");
    if (errors == 0 && pending_results.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end
endmodule
